// ===== rtl/ucw_pkg.sv =====
// ----------------------------------------------------------------------------
// ucw_pkg
// Shared types, constants and helpers for the UTF-8 cell writer.
// ----------------------------------------------------------------------------
package ucw_pkg;

  // cells one input byte can produce at most
  localparam int CELLS       = 4;
  // depth of the job queue between decoder and cell writer
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QLVL_W      = $clog2(QDEPTH + 1);

  // configuration register indexes
  localparam logic CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic CFG_SCREEN_HEIGHT = 1'b1;

  localparam logic [7:0] WIDTH_RESET  = 8'd62;
  localparam logic [7:0] HEIGHT_RESET = 8'd18;

  // replacement character
  localparam logic [7:0] QMARK_BYTE = 8'h3F;

  // code point limits
  localparam logic [20:0] CP_MIN2     = 21'h000080;
  localparam logic [20:0] CP_MIN3     = 21'h000800;
  localparam logic [20:0] CP_MIN4     = 21'h010000;
  localparam logic [20:0] CP_MAX      = 21'h10FFFF;
  localparam logic [20:0] CP_COMB_LO  = 21'h000300;
  localparam logic [20:0] CP_COMB_HI  = 21'h00036F;
  localparam logic [20:0] CP_VS_LO    = 21'h00FE00;
  localparam logic [20:0] CP_VS_HI    = 21'h00FE0F;
  localparam logic [20:0] CP_JAMO_LO  = 21'h001100;
  localparam logic [20:0] CP_JAMO_HI  = 21'h00115F;
  localparam logic [20:0] CP_CJK_LO   = 21'h002E80;
  localparam logic [20:0] CP_CJK_HI   = 21'h00A4CF;
  localparam logic [20:0] CP_HANG_LO  = 21'h00AC00;
  localparam logic [20:0] CP_HANG_HI  = 21'h00D7A3;
  localparam logic [20:0] CP_FW_LO    = 21'h00FF00;
  localparam logic [20:0] CP_FW_HI    = 21'h00FF60;

  // what a queued cell slot holds
  typedef enum logic [1:0] {
    KIND_QMARK = 2'b00,
    KIND_CHAR  = 2'b01,
    KIND_CONT  = 2'b10
  } ucw_kind_t;

  // one decoded byte: up to four cells, only visible ones flagged in mask
  typedef struct packed {
    logic      [CELLS-1:0]      mask;
    ucw_kind_t [CELLS-1:0]      kind;
    logic      [CELLS-1:0][7:0] col;
    logic      [7:0]            row;
    logic      [31:0]           bytes;
    logic      [2:0]            count;
  } ucw_job_t;

  // queue status seen by both sides
  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QLVL_W-1:0] level;
  } ucw_q_status_t;

  // display width of a code point: 0, 1 or 2 cells
  function automatic logic [1:0] char_width(input logic [20:0] cp);
    logic zero_w;
    logic wide;
    zero_w = (cp >= CP_COMB_LO && cp <= CP_COMB_HI) ||
             (cp >= CP_VS_LO && cp <= CP_VS_HI);
    wide   = (cp >= CP_JAMO_LO && cp <= CP_JAMO_HI) ||
             (cp >= CP_CJK_LO && cp <= CP_CJK_HI) ||
             (cp >= CP_HANG_LO && cp <= CP_HANG_HI) ||
             (cp >= CP_FW_LO && cp <= CP_FW_HI);
    if (zero_w) begin
      return 2'd0;
    end else if (wide) begin
      return 2'd2;
    end else begin
      return 2'd1;
    end
  endfunction

  // column saturating at 255
  function automatic logic [7:0] sat_col(input logic [8:0] sum);
    return sum[8] ? 8'hFF : sum[7:0];
  endfunction

endpackage

// ===== rtl/utf8_cell_writer.sv =====
// ----------------------------------------------------------------------------
// utf8_cell_writer
// Streaming UTF-8 text writer for a character-cell screen: decodes bytes,
// replaces broken sequences with '?', and emits one transfer per cell.
//
//   channel | handshake                  | payload
//   --------+----------------------------+-------------------------------------
//   in      | in_valid / in_stall        | data_byte, first_of_string,
//           |                            | last_of_string, start_col, row_index
//   out     | out_valid / out_stall      | cell_col, cell_row, cell_bytes,
//           |                            | byte_count, last_of_run
//   cfg     | cfg_write, cfg_index       | cfg_data (screen width / height)
//
// One byte is taken per cycle while the four-entry job queue has room.
// The cell writer drives one cell per cycle while out_stall is low, so a byte
// that writes n cells makes a burst of n transfers; the queue soaks those up.
// A byte's first cell passes through the job queue, then the output register.
// Reset is synchronous; it clears decoder state, queue and output valid.
// in_stall is the queue-full flag only; out_stall acts on it via queue fill.
// ----------------------------------------------------------------------------
module utf8_cell_writer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        first_of_string,
  input  logic        last_of_string,
  input  logic [7:0]  start_col,
  input  logic [7:0]  row_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  cell_col,
  output logic [7:0]  cell_row,
  output logic [31:0] cell_bytes,
  output logic [2:0]  byte_count,
  output logic        last_of_run,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import ucw_pkg::*;

  logic          accept;
  logic          push;
  logic          pop;
  logic          take;
  logic          job_valid;
  ucw_job_t      job;
  ucw_job_t      head;
  ucw_q_status_t q_status;
  logic [7:0]    screen_width;
  logic [7:0]    screen_height;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // input transfer and queue push
  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;
  assign push     = accept && job_valid;

  ucw_front u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .data_byte       (data_byte),
    .first_of_string (first_of_string),
    .last_of_string  (last_of_string),
    .start_col       (start_col),
    .row_index       (row_index),
    .screen_width    (screen_width),
    .screen_height   (screen_height),
    .job             (job),
    .job_valid       (job_valid)
  );

  ucw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (job),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  ucw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_status    (q_status),
    .pop         (pop),
    .take        (take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cell_col    (cell_col),
    .cell_row    (cell_row),
    .cell_bytes  (cell_bytes),
    .byte_count  (byte_count),
    .last_of_run (last_of_run)
  );

  // queue level stays within its depth
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    q_status.level <= QLVL_W'(QDEPTH))
    else $error("job queue level beyond depth");

  // a job pushed into an idle block passes the queue and reaches the output
  a_push_to_out: assert property (@(posedge clk) disable iff (rst)
    push && q_status.empty && !out_valid |-> ##2 out_valid)
    else $error("pushed job did not reach the output");

  // the queue is only popped by a taken cell
  a_pop_take: assert property (@(posedge clk) disable iff (rst)
    pop |-> take && !q_status.empty)
    else $error("queue popped without a cell transfer");

  // a wide continuation cell carries no bytes
  a_cont_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_count == 3'd0 |-> cell_bytes == 32'd0 && cell_col != 8'd0)
    else $error("continuation cell with data");

endmodule

// ===== rtl/ucw_front.sv =====
// ----------------------------------------------------------------------------
// ucw_front
// Byte decoder: tracks the pending UTF-8 sequence and cursor, and turns each
// accepted byte into a job of up to four screen cells.
// ----------------------------------------------------------------------------
module ucw_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  input  logic            first_of_string,
  input  logic            last_of_string,
  input  logic [7:0]      start_col,
  input  logic [7:0]      row_index,
  input  logic [7:0]      screen_width,
  input  logic [7:0]      screen_height,
  output ucw_pkg::ucw_job_t job,
  output logic            job_valid
);
  import ucw_pkg::*;

  // decoder state
  logic [23:0] pending_bytes;
  logic [1:0]  pending_count;
  logic [2:0]  expected_length;
  logic [7:0]  cursor_col;
  logic [7:0]  current_row;

  logic [23:0] pending_bytes_next;
  logic [1:0]  pending_count_next;
  logic [2:0]  expected_length_next;
  logic [7:0]  cursor_col_next;

  // working values
  logic [7:0]  cur;
  logic [7:0]  row;
  logic [1:0]  pc;
  logic [23:0] pb;
  logic [2:0]  el;
  logic        cont;
  logic [31:0] all;
  logic [20:0] cp;
  logic        ok;
  logic [2:0]  nq;
  logic [1:0]  w;
  logic [31:0] ch_bytes;
  logic [2:0]  ch_count;
  logic [7:0]  c1;
  logic [8:0]  cont_col;
  logic        row_vis;

  // sequence assembly and classification
  always_comb begin
    cur   = first_of_string ? start_col : cursor_col;
    row   = first_of_string ? row_index : current_row;
    pc    = first_of_string ? 2'd0  : pending_count;
    pb    = first_of_string ? 24'd0 : pending_bytes;
    el    = first_of_string ? 3'd0  : expected_length;
    cont  = (data_byte[7:6] == 2'b10);
    all   = {8'd0, pb} | ({24'd0, data_byte} << {pc, 3'b000});
    nq    = 3'd0;
    w     = 2'd0;
    ok    = 1'b0;
    cp    = '0;
    ch_bytes = {24'd0, data_byte};
    ch_count = 3'd1;
    pending_count_next   = pc;
    pending_bytes_next   = pb;
    expected_length_next = el;

    if (pc == 2'd0 || !cont) begin
      // broken sequence flushes as one '?' per buffered byte
      nq = {1'b0, pc};
      pending_count_next   = 2'd0;
      pending_bytes_next   = 24'd0;
      expected_length_next = 3'd0;
      if (!data_byte[7]) begin
        w = 2'd1;
      end else if (data_byte[7:5] == 3'b110) begin
        expected_length_next = 3'd2;
        pending_count_next   = 2'd1;
        pending_bytes_next   = {16'd0, data_byte};
      end else if (data_byte[7:4] == 4'b1110) begin
        expected_length_next = 3'd3;
        pending_count_next   = 2'd1;
        pending_bytes_next   = {16'd0, data_byte};
      end else if (data_byte[7:3] == 5'b11110) begin
        expected_length_next = 3'd4;
        pending_count_next   = 2'd1;
        pending_bytes_next   = {16'd0, data_byte};
      end else begin
        nq = nq + 3'd1;
      end
    end else if (({1'b0, pc} + 3'd1) >= el) begin
      // sequence complete
      pending_count_next   = 2'd0;
      pending_bytes_next   = 24'd0;
      expected_length_next = 3'd0;
      ch_bytes = all;
      ch_count = el;
      case (el)
        3'd2: begin
          cp = {10'd0, all[4:0], all[13:8]};
          ok = (cp >= CP_MIN2);
        end
        3'd3: begin
          cp = {5'd0, all[3:0], all[13:8], all[21:16]};
          ok = (cp >= CP_MIN3);
        end
        default: begin
          cp = {all[2:0], all[13:8], all[21:16], all[29:24]};
          ok = (cp >= CP_MIN4) && (cp <= CP_MAX);
        end
      endcase
      if (ok) begin
        w = char_width(cp);
      end else begin
        nq = el;
      end
    end else begin
      pending_bytes_next = all[23:0];
      pending_count_next = pc + 2'd1;
    end

    // string end flushes what is still buffered
    if (last_of_string && pending_count_next != 2'd0) begin
      nq = nq + {1'b0, pending_count_next};
      pending_count_next   = 2'd0;
      pending_bytes_next   = 24'd0;
      expected_length_next = 3'd0;
    end
  end

  // cell placement and screen clipping
  always_comb begin
    c1       = sat_col({1'b0, cur} + {6'd0, nq});
    cont_col = {1'b0, c1} + 9'd1;
    row_vis  = (row < screen_height);
    cursor_col_next = sat_col({1'b0, cur} + {6'd0, nq} + {7'd0, w});
    job.row   = row;
    job.bytes = ch_bytes;
    job.count = ch_count;
    for (int k = 0; k < CELLS; k++) begin
      job.mask[k] = 1'b0;
      job.kind[k] = KIND_QMARK;
      job.col[k]  = sat_col({1'b0, cur} + 9'(k));
      if (3'(k) < nq) begin
        job.mask[k] = row_vis && (job.col[k] < screen_width);
      end else if (3'(k) == nq && w != 2'd0) begin
        job.kind[k] = KIND_CHAR;
        job.col[k]  = c1;
        job.mask[k] = row_vis && (c1 < screen_width);
      end else if (3'(k) == nq + 3'd1 && w == 2'd2) begin
        job.kind[k] = KIND_CONT;
        job.col[k]  = cont_col[7:0];
        job.mask[k] = row_vis && !cont_col[8] && (cont_col[7:0] < screen_width);
      end
    end
    job_valid = (job.mask != '0);
  end

  // state update on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bytes   <= 24'd0;
      pending_count   <= 2'd0;
      expected_length <= 3'd0;
      cursor_col      <= 8'd0;
      current_row     <= 8'd0;
    end else if (accept) begin
      pending_bytes   <= pending_bytes_next;
      pending_count   <= pending_count_next;
      expected_length <= expected_length_next;
      cursor_col      <= cursor_col_next;
      current_row     <= row;
    end
  end

endmodule

// ===== rtl/ucw_queue.sv =====
// ----------------------------------------------------------------------------
// ucw_queue
// Small job queue between the byte decoder and the cell writer.
// ----------------------------------------------------------------------------
module ucw_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  ucw_pkg::ucw_job_t     push_job,
  input  logic                  pop,
  output ucw_pkg::ucw_job_t     head,
  output ucw_pkg::ucw_q_status_t status
);
  import ucw_pkg::*;

  ucw_job_t            entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QLVL_W-1:0]   level;

  // status and head entry
  always_comb begin
    status.level = level;
    status.empty = (level == QLVL_W'(0));
    status.full  = (level == QLVL_W'(QDEPTH));
    head         = entries[rd_ptr];
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      level <= level + QLVL_W'(push) - QLVL_W'(pop);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== rtl/ucw_back.sv =====
// ----------------------------------------------------------------------------
// ucw_back
// Cell writer: walks the visible cells of the head job, one per cycle while
// the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module ucw_back (
  input  logic                   clk,
  input  logic                   rst,
  input  ucw_pkg::ucw_job_t      head,
  input  ucw_pkg::ucw_q_status_t q_status,
  output logic                   pop,
  output logic                   take,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             cell_col,
  output logic [7:0]             cell_row,
  output logic [31:0]            cell_bytes,
  output logic [2:0]             byte_count,
  output logic                   last_of_run
);
  import ucw_pkg::*;

  logic [CELLS-1:0] sent;
  logic [CELLS-1:0] rem;
  logic [CELLS-1:0] sel;
  logic             last;
  logic [7:0]       sel_col;
  ucw_kind_t        sel_kind;
  logic [31:0]      sel_bytes;
  logic [2:0]       sel_count;

  // lowest remaining visible cell of the head job
  always_comb begin
    rem  = head.mask & ~sent;
    sel  = rem & (~rem + CELLS'(1));
    last = ((rem & ~sel) == '0);
    take = !q_status.empty && (!out_valid || !out_stall);
    pop  = take && last;
    sel_col  = head.col[0];
    sel_kind = head.kind[0];
    for (int k = 0; k < CELLS; k++) begin
      if (sel[k]) begin
        sel_col  = head.col[k];
        sel_kind = head.kind[k];
      end
    end
    case (sel_kind)
      KIND_CHAR: begin
        sel_bytes = head.bytes;
        sel_count = head.count;
      end
      KIND_CONT: begin
        sel_bytes = 32'd0;
        sel_count = 3'd0;
      end
      default: begin
        sel_bytes = {24'd0, QMARK_BYTE};
        sel_count = 3'd1;
      end
    endcase
  end

  // control: progress through the head job and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      sent      <= '0;
      out_valid <= 1'b0;
    end else if (take) begin
      sent      <= last ? '0 : (sent | sel);
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (take) begin
      cell_col    <= sel_col;
      cell_row    <= head.row;
      cell_bytes  <= sel_bytes;
      byte_count  <= sel_count;
      last_of_run <= last;
    end
  end

endmodule

// ===== sim/utf8_cell_writer_test.sv =====
// ----------------------------------------------------------------------------
// utf8_cell_writer_test
// Self-checking bench for the UTF-8 cell writer. Bytes of generated text
// strings go in with random gaps, and the output is stalled at random. Every
// accepted byte is run through a local decoder that tracks pending bytes,
// cursor and row and gives the cells it should write. Each output transfer
// is compared field by field with the oldest cell still due.
// ----------------------------------------------------------------------------
module utf8_cell_writer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ucw_pkg::*;

  // settle time after the last due cell has come out of the block
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    logic [7:0]  col;
    logic [7:0]  row;
    logic [31:0] bytes;
    logic [2:0]  nbytes;
    logic        is_last;
  } cell_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        first_of_string;
  logic        last_of_string;
  logic [7:0]  start_col;
  logic [7:0]  row_index;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  cell_col;
  logic [7:0]  cell_row;
  logic [31:0] cell_bytes;
  logic [2:0]  byte_count;
  logic        last_of_run;
  logic        cfg_write;
  logic        cfg_index;
  logic [7:0]  cfg_data;

  // decoder state mirrored by the bench
  int          scr_w = WIDTH_RESET;
  int          scr_h = HEIGHT_RESET;
  logic [23:0] pend_bytes = '0;
  int          pend_cnt = 0;
  int          seq_len = 0;
  int          cur_col = 0;
  logic [7:0]  cur_row = '0;

  cell_t       step_cells[$];
  cell_t       cells_due[$];
  cell_t       due_c;
  logic [7:0]  text_q[$];

  int          mismatches = 0;
  bit          sender_gaps = 1'b1;
  int          hold_req = 0;
  int          hold_left = 0;
  int          run_left = 0;
  bit          run_stall = 1'b0;
  int          pick;

  utf8_cell_writer dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .first_of_string (first_of_string),
    .last_of_string  (last_of_string),
    .start_col       (start_col),
    .row_index       (row_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .cell_col        (cell_col),
    .cell_row        (cell_row),
    .cell_bytes      (cell_bytes),
    .byte_count      (byte_count),
    .last_of_run     (last_of_run),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // cell prediction
  // ---------------------------------------------------------------------------

  // cell is kept only when on screen, at most four per byte
  function automatic void keep_cell(int col, logic [31:0] bytes, logic [2:0] nbytes);
    cell_t c;
    if (col >= scr_w || cur_row >= scr_h || step_cells.size() >= CELLS) return;
    c.col     = col[7:0];
    c.row     = cur_row;
    c.bytes   = bytes;
    c.nbytes  = nbytes;
    c.is_last = 1'b0;
    step_cells.push_back(c);
  endfunction

  // cursor stops at column 255
  function automatic void move_cursor(int w);
    cur_col = (cur_col + w > 255) ? 255 : cur_col + w;
  endfunction

  function automatic void put_qmark();
    keep_cell(cur_col, {24'd0, QMARK_BYTE}, 3'd1);
    move_cursor(1);
  endfunction

  function automatic int glyph_cols(logic [20:0] cp);
    if ((cp >= CP_COMB_LO && cp <= CP_COMB_HI) || (cp >= CP_VS_LO && cp <= CP_VS_HI))
      return 0;
    if ((cp >= CP_JAMO_LO && cp <= CP_JAMO_HI) || (cp >= CP_CJK_LO && cp <= CP_CJK_HI) ||
        (cp >= CP_HANG_LO && cp <= CP_HANG_HI) || (cp >= CP_FW_LO && cp <= CP_FW_HI))
      return 2;
    return 1;
  endfunction

  // wide glyphs take an empty cell to their right
  function automatic void put_glyph(logic [20:0] cp, logic [31:0] bytes, logic [2:0] nbytes);
    int w;
    w = glyph_cols(cp);
    if (w == 0) return;
    keep_cell(cur_col, bytes, nbytes);
    if (w == 2) keep_cell(cur_col + 1, 32'd0, 3'd0);
    move_cursor(w);
  endfunction

  function automatic void flush_pend();
    for (int i = 0; i < pend_cnt; i++) put_qmark();
    pend_bytes = '0;
    pend_cnt   = 0;
    seq_len    = 0;
  endfunction

  function automatic void lead_byte(logic [7:0] b);
    if (b < 8'h80) begin
      put_glyph({13'd0, b}, {24'd0, b}, 3'd1);
      return;
    end
    if (b[7:5] == 3'b110) seq_len = 2;
    else if (b[7:4] == 4'b1110) seq_len = 3;
    else if (b[7:3] == 5'b11110) seq_len = 4;
    else begin
      put_qmark();
      return;
    end
    pend_bytes = {16'd0, b};
    pend_cnt   = 1;
  endfunction

  // complete sequence: glyph if in range and shortest form, else one '?' per byte
  function automatic void close_seq(logic [31:0] all);
    logic [7:0]  b0;
    logic [5:0]  b1;
    logic [5:0]  b2;
    logic [5:0]  b3;
    logic [20:0] cp;
    logic        ok;
    int          n;
    n  = seq_len;
    b0 = all[7:0];
    b1 = all[13:8];
    b2 = all[21:16];
    b3 = all[29:24];
    if (n == 2) begin
      cp = {10'd0, b0[4:0], b1};
      ok = cp >= CP_MIN2;
    end else if (n == 3) begin
      cp = {5'd0, b0[3:0], b1, b2};
      ok = cp >= CP_MIN3;
    end else begin
      cp = {b0[2:0], b1, b2, b3};
      ok = cp >= CP_MIN4 && cp <= CP_MAX;
    end
    pend_bytes = '0;
    pend_cnt   = 0;
    seq_len    = 0;
    if (ok) put_glyph(cp, all, n[2:0]);
    else for (int i = 0; i < n; i++) put_qmark();
  endfunction

  // one accepted byte: queue up the cells it writes
  function automatic void decode_byte(logic [7:0] b, logic first, logic is_last,
                                      logic [7:0] scol, logic [7:0] row);
    logic [31:0] all;
    cell_t       c;
    step_cells.delete();
    if (first) begin
      cur_col    = scol;
      cur_row    = row;
      pend_bytes = '0;
      pend_cnt   = 0;
      seq_len    = 0;
    end
    if (pend_cnt == 0) begin
      lead_byte(b);
    end else if (b[7:6] == 2'b10) begin
      all = {8'd0, pend_bytes} | ({24'd0, b} << (8 * pend_cnt));
      if (pend_cnt + 1 >= seq_len) begin
        close_seq(all);
      end else begin
        pend_bytes = all[23:0];
        pend_cnt   = pend_cnt + 1;
      end
    end else begin
      flush_pend();
      lead_byte(b);
    end
    if (is_last && pend_cnt > 0) flush_pend();
    for (int i = 0; i < step_cells.size(); i++) begin
      c = step_cells[i];
      c.is_last = (i == step_cells.size() - 1);
      cells_due.push_back(c);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // output side: random stall and checking
  // ---------------------------------------------------------------------------

  // stall pattern in runs; a requested hold-off overrides it
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (run_left == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          run_stall = 1'b0;
          run_left  = $urandom_range(20, 60);
        end else if (pick < 55) begin
          run_stall = 1'b0;
          run_left  = $urandom_range(1, 4);
        end else if (pick < 90) begin
          run_stall = 1'b1;
          run_left  = $urandom_range(1, 3);
        end else if (pick < 97) begin
          run_stall = 1'b1;
          run_left  = $urandom_range(4, 12);
        end else begin
          run_stall = 1'b1;
          run_left  = $urandom_range(20, 50);
        end
      end
      run_left = run_left - 1;
      out_stall <= run_stall;
    end
  end

  // compare each output transfer with the oldest cell due
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (cells_due.size() == 0) begin
        $error("unexpected cell transfer: col %0d row %0d bytes %h", cell_col, cell_row,
               cell_bytes);
        mismatches++;
      end else begin
        due_c = cells_due.pop_front();
        if (cell_col !== due_c.col) begin
          $error("cell_col: expected %0d, got %0d", due_c.col, cell_col);
          mismatches++;
        end
        if (cell_row !== due_c.row) begin
          $error("cell_row: expected %0d, got %0d", due_c.row, cell_row);
          mismatches++;
        end
        if (cell_bytes !== due_c.bytes) begin
          $error("cell_bytes: expected %h, got %h", due_c.bytes, cell_bytes);
          mismatches++;
        end
        if (byte_count !== due_c.nbytes) begin
          $error("byte_count: expected %0d, got %0d", due_c.nbytes, byte_count);
          mismatches++;
        end
        if (last_of_run !== due_c.is_last) begin
          $error("last_of_run: expected %0d, got %0d", due_c.is_last, last_of_run);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // mostly back to back, sometimes short gaps, rarely long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic first, input logic is_last,
                           input logic [7:0] scol, input logic [7:0] row);
    int gap;
    gap = sender_gaps ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    data_byte       <= b;
    first_of_string <= first;
    last_of_string  <= is_last;
    start_col       <= scol;
    row_index       <= row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(b, first, is_last, scol, row);
  endtask

  // send the bytes in text_q; position fields are noise on non-opening bytes
  task automatic send_text(input logic [7:0] scol, input logic [7:0] row, input bit opening,
                           input bit terminate);
    int n;
    n = text_q.size();
    for (int i = 0; i < n; i++) begin
      send_byte(text_q[i], opening && i == 0, terminate && i == n - 1,
                (opening && i == 0) ? scol : 8'($urandom_range(0, 255)),
                (opening && i == 0) ? row : 8'($urandom_range(0, 255)));
    end
    text_q.delete();
  endtask

  task automatic sender_idle();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // sender waits until every due cell has come out and the queue is empty
  task automatic wait_drained();
    sender_idle();
    while (cells_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_SCREEN_WIDTH) scr_w = val;
    else scr_h = val;
  endtask

  // ---------------------------------------------------------------------------
  // text generation
  // ---------------------------------------------------------------------------

  function automatic void push_utf8(logic [20:0] v, int n);
    case (n)
      1: text_q.push_back({1'b0, v[6:0]});
      2: begin
        text_q.push_back({3'b110, v[10:6]});
        text_q.push_back({2'b10, v[5:0]});
      end
      3: begin
        text_q.push_back({4'b1110, v[15:12]});
        text_q.push_back({2'b10, v[11:6]});
        text_q.push_back({2'b10, v[5:0]});
      end
      default: begin
        text_q.push_back({5'b11110, v[20:18]});
        text_q.push_back({2'b10, v[17:12]});
        text_q.push_back({2'b10, v[11:6]});
        text_q.push_back({2'b10, v[5:0]});
      end
    endcase
  endfunction

  function automatic logic [20:0] pick_3byte_cp();
    case ($urandom_range(0, 6))
      0: return 21'($urandom_range(CP_JAMO_LO, CP_JAMO_HI));
      1: return 21'($urandom_range(CP_CJK_LO, CP_CJK_HI));
      2: return 21'($urandom_range(CP_HANG_LO, CP_HANG_HI));
      3: return 21'($urandom_range(CP_FW_LO, CP_FW_HI));
      4: return 21'($urandom_range(CP_VS_LO, CP_VS_HI));
      5: return 21'($urandom_range(21'h00D800, 21'h00DFFF));
      default: return 21'($urandom_range(CP_MIN3, 21'h00FFFF));
    endcase
  endfunction

  // one character, well formed most of the time
  function automatic void add_random_char();
    int r;
    int n;
    int k;
    r = $urandom_range(0, 99);
    if (r == 0) begin
      text_q.push_back(8'h00);
    end else if (r < 28) begin
      text_q.push_back(8'($urandom_range(1, 127)));
    end else if (r < 42) begin
      push_utf8(21'($urandom_range(CP_MIN2, CP_MIN3 - 1)), 2);
    end else if (r < 60) begin
      push_utf8(pick_3byte_cp(), 3);
    end else if (r < 68) begin
      push_utf8(21'($urandom_range(CP_MIN4, CP_MAX)), 4);
    end else if (r < 73) begin
      push_utf8(21'($urandom_range(CP_COMB_LO, CP_COMB_HI)), 2);
    end else if (r < 78) begin
      // overlong form
      n = $urandom_range(2, 4);
      if (n == 2) push_utf8(21'($urandom_range(0, CP_MIN2 - 1)), 2);
      else if (n == 3) push_utf8(21'($urandom_range(0, CP_MIN3 - 1)), 3);
      else push_utf8(21'($urandom_range(0, CP_MIN4 - 1)), 4);
    end else if (r < 82) begin
      push_utf8(21'($urandom_range(CP_MAX + 1, 21'h1FFFFF)), 4);
    end else if (r < 89) begin
      // truncated sequence, broken by whatever follows
      n = $urandom_range(2, 4);
      k = $urandom_range(1, n - 1);
      push_utf8(21'($urandom_range(CP_MIN4, CP_MAX)) >> (n == 4 ? 0 : (n == 3 ? 5 : 10)) |
                (n == 2 ? CP_MIN2 : (n == 3 ? CP_MIN3 : 21'd0)), n);
      repeat (n - k) void'(text_q.pop_back());
    end else if (r < 94) begin
      text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
    end else begin
      text_q.push_back(8'($urandom_range(8'hC0, 8'hFF)));
    end
  endfunction

  function automatic logic [7:0] pick_pos(int limit);
    if ($urandom_range(0, 99) < 75 && limit > 0) return 8'($urandom_range(0, limit - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random_strings(input int nbytes_goal);
    int sent;
    int nchars;
    bit term;
    sent = 0;
    while (sent < nbytes_goal) begin
      nchars = $urandom_range(1, 6);
      repeat (nchars) add_random_char();
      sent = sent + text_q.size();
      term = $urandom_range(0, 9) != 0;
      send_text(pick_pos(scr_w), pick_pos(scr_h), 1'b1, term);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every sequence kind once at reset settings
  task automatic test_decode_cases();
    text_q = '{8'h41, 8'h00, 8'hE4, 8'hB8, 8'hAD, 8'hF0, 8'h9F, 8'h98, 8'h80,
               8'hCC, 8'h81, 8'hEF, 8'hB8, 8'h8F, 8'hC1, 8'hBF,
               8'hF4, 8'h90, 8'h80, 8'h80, 8'hED, 8'hA0, 8'h80,
               8'h80, 8'hFF, 8'hE4, 8'h41, 8'hE4, 8'hB8};
    send_text(8'd0, 8'd2, 1'b1, 1'b1);
    // unfinished sequence dropped silently by the next string
    text_q = '{8'hF0, 8'h9F};
    send_text(8'd5, 8'd3, 1'b1, 1'b0);
    text_q = '{8'h43};
    send_text(8'd61, 8'd17, 1'b1, 1'b1);
  endtask

  // zero width, full size screen and column saturation
  task automatic test_screen_edges();
    wait_drained();
    write_reg(CFG_SCREEN_WIDTH, 8'd0);
    text_q = '{8'h41};
    send_text(8'd0, 8'd0, 1'b1, 1'b1);
    wait_drained();
    write_reg(CFG_SCREEN_WIDTH, 8'd255);
    write_reg(CFG_SCREEN_HEIGHT, 8'd255);
    text_q = '{8'hE4, 8'hB8, 8'hAD, 8'hE4, 8'hB8, 8'hAD, 8'h5A};
    send_text(8'd252, 8'd254, 1'b1, 1'b1);
    text_q = '{8'h51};
    send_text(8'd0, 8'd255, 1'b1, 1'b1);
  endtask

  // random text over several screen sizes, extremes first
  task automatic test_random_text();
    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          write_reg(CFG_SCREEN_WIDTH, 8'd1);
          write_reg(CFG_SCREEN_HEIGHT, 8'd1);
        end
        1: begin
          write_reg(CFG_SCREEN_WIDTH, 8'd255);
          write_reg(CFG_SCREEN_HEIGHT, 8'd255);
        end
        default: begin
          write_reg(CFG_SCREEN_WIDTH, 8'($urandom_range(1, 255)));
          write_reg(CFG_SCREEN_HEIGHT, 8'($urandom_range(1, 255)));
        end
      endcase
      // one phase without sender gaps
      sender_gaps = (phase != 2);
      send_random_strings(10);
      if (phase == 3) wait_drained();
      send_random_strings(10);
    end
    sender_gaps = 1'b1;
  endtask

  // receiver holds off while bytes keep coming, so the input stalls
  task automatic test_backpressure();
    wait_drained();
    write_reg(CFG_SCREEN_WIDTH, 8'd120);
    write_reg(CFG_SCREEN_HEIGHT, 8'd40);
    sender_gaps = 1'b0;
    hold_req = 150;
    repeat (3) begin
      repeat (10) add_random_char();
      send_text(8'($urandom_range(0, 100)), 8'($urandom_range(0, 39)), 1'b1, 1'b1);
    end
    sender_gaps = 1'b1;
  endtask

  // pending bytes survive an idle stretch on the input
  task automatic test_pause_resume();
    wait_drained();
    text_q = '{8'hE4, 8'hB8};
    send_text(8'd3, 8'd1, 1'b1, 1'b0);
    wait_drained();
    text_q = '{8'hAD, 8'hC3, 8'hA9};
    send_text(8'd0, 8'd0, 1'b0, 1'b1);
  endtask

  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    data_byte       = '0;
    first_of_string = 1'b0;
    last_of_string  = 1'b0;
    start_col       = '0;
    row_index       = '0;
    cfg_write       = 1'b0;
    cfg_index       = CFG_SCREEN_WIDTH;
    cfg_data        = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_decode_cases();
    test_screen_edges();
    test_random_text();
    test_backpressure();
    test_pause_resume();

    wait_drained();
    if (mismatches == 0 && cells_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
